[rtl/mdeu_pkg.sv]
// Shared types and constants of the multiply/divide execution unit.
// Depends on nothing.
package mdeu_pkg;

    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_MULU = 2'd2;
    localparam logic [1:0] OP_MULS = 2'd3;

    localparam logic [1:0] W_8    = 2'd0;
    localparam logic [1:0] W_16   = 2'd1;
    localparam logic [1:0] W_32   = 2'd2;
    localparam logic [1:0] W_RSVD = 2'd3;

    localparam logic [1:0] EXT_NONE = 2'd0;
    localparam logic [1:0] EXT_8    = 2'd1;
    localparam logic [1:0] EXT_16   = 2'd2;
    localparam logic [1:0] EXT_RSVD = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  operand_width;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [1:0]  b_extend;
    } req_t;

    typedef struct packed {
        logic [31:0] result_low;
        logic [31:0] result_high;
        logic        zero_flag;
        logic        negative_flag;
        logic        odd_flag;
        logic        div_by_zero;
    } rsp_t;

    // classified operation handed from front to back
    typedef struct packed {
        logic        is_div;
        logic        is_wide;
        logic        is_signed;
        logic [1:0]  width;
        logic [31:0] a;
        logic [31:0] b;
    } op_t;

endpackage

[rtl/mdeu_front.sv]
// Front part: accepts items, masks and extends operands, fills the queue.
// Depends on mdeu_pkg.
module mdeu_front
    import mdeu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic q_valid,
    input  logic q_ready,
    output op_t  q_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    op_t            mem [DEPTH];
    logic [AW-1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]    cnt_reg, cnt_next;
    op_t            cls;
    logic [31:0]    b_ext;
    logic           push, pop;

    always_comb
    begin
        unique case (in_data.b_extend)
            EXT_8:   b_ext = {{24{in_data.operand_b[7]}}, in_data.operand_b[7:0]};
            EXT_16:  b_ext = {{16{in_data.operand_b[15]}}, in_data.operand_b[15:0]};
            default: b_ext = in_data.operand_b;
        endcase
        cls.is_div    = (in_data.req_type == OP_DIV);
        cls.is_wide   = (in_data.req_type == OP_MULU) || (in_data.req_type == OP_MULS);
        cls.is_signed = (in_data.req_type == OP_MULS);
        cls.b         = b_ext;
        if (cls.is_wide)
        begin
            cls.width = W_32;
            cls.a     = in_data.operand_a;
        end
        else
        begin
            cls.width = in_data.operand_width;
            unique case (in_data.operand_width)
                W_8:     cls.a = {24'd0, in_data.operand_a[7:0]};
                W_16:    cls.a = {16'd0, in_data.operand_a[15:0]};
                default: cls.a = in_data.operand_a;
            endcase
        end
    end

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = mem[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_next  = push ? ((wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? ((rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= cls;
    end

endmodule

[rtl/mdeu_div.sv]
// Pipelined radix-2 unsigned divider, one quotient bit per stage, 32 stages.
// Depends on mdeu_pkg.
module mdeu_div
    import mdeu_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] q
);
    logic [31:0] rem_reg [33];
    logic [31:0] quo_reg [33];
    logic [31:0] den_reg [33];

    always_comb
    begin
        rem_reg[0] = '0;
        quo_reg[0] = a;
        den_reg[0] = b;
    end

    for (genvar i = 0; i < 32; i++)
    begin : g_stage
        logic [32:0] shifted;
        logic [32:0] diff;
        assign shifted = {rem_reg[i], quo_reg[i][31]};
        assign diff    = shifted - {1'b0, den_reg[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[i+1] <= den_reg[i];
                if (!diff[32])
                begin
                    rem_reg[i+1] <= diff[31:0];
                    quo_reg[i+1] <= {quo_reg[i][30:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= shifted[31:0];
                    quo_reg[i+1] <= {quo_reg[i][30:0], 1'b0};
                end
            end
        end
    end

    assign q = quo_reg[32];

endmodule

[rtl/mdeu_back.sv]
// Back part: 32-stage stallable pipeline, multiplies and divides, forms flags.
// Depends on mdeu_pkg and mdeu_div.
module mdeu_back
    import mdeu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_ready,
    input  op_t  q_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);
    // must match the depth of the quotient pipe
    localparam int STAGES = 32;

    typedef struct packed {
        logic       is_div;
        logic       is_wide;
        logic       dz;
        logic [1:0] width;
    } ctl_t;

    logic [STAGES-1:0] vld_reg;
    ctl_t              ctl_reg [STAGES];
    logic [63:0]       prod_reg [STAGES];
    logic [31:0]       corr_reg;
    logic              adv;
    logic [31:0]       quo;
    logic [63:0]       uprod;
    logic [31:0]       corr;
    ctl_t              ctl0;
    rsp_t              rsp_next, rsp_reg;
    logic              ovld_reg;
    logic [31:0]       r, m, sgn;
    logic [63:0]       p;
    ctl_t              cl;

    // whole pipe moves when its last stage can drain into the output register
    assign adv     = !vld_reg[STAGES-1] || !ovld_reg || out_ready;
    assign q_ready = adv;

    always_comb
    begin
        uprod = 64'(q_data.a) * 64'(q_data.b);
        // signed product: subtract each operand from the high word when the other is negative
        corr  = ((q_data.is_signed && q_data.a[31]) ? q_data.b : 32'd0)
              + ((q_data.is_signed && q_data.b[31]) ? q_data.a : 32'd0);
        ctl0.is_div  = q_data.is_div;
        ctl0.is_wide = q_data.is_wide;
        ctl0.dz      = q_data.is_div && (q_data.b == '0);
        ctl0.width   = q_data.width;
    end

    mdeu_div u_div (
        .clk (clk),
        .en  (adv),
        .a   (q_data.a),
        .b   (q_data.b),
        .q   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[STAGES-2:0], q_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0]  <= ctl0;
            prod_reg[0] <= uprod;
            corr_reg    <= corr;
            ctl_reg[1]  <= ctl_reg[0];
            prod_reg[1] <= prod_reg[0] - {corr_reg, 32'd0};
            for (int i = 2; i < STAGES; i++)
            begin
                ctl_reg[i]  <= ctl_reg[i-1];
                prod_reg[i] <= prod_reg[i-1];
            end
        end
    end

    always_comb
    begin
        cl = ctl_reg[STAGES-1];
        p  = prod_reg[STAGES-1];
        unique case (cl.width)
            W_8:     begin m = 32'h0000_00FF; sgn = 32'h0000_0080; end
            W_16:    begin m = 32'h0000_FFFF; sgn = 32'h0000_8000; end
            default: begin m = 32'hFFFF_FFFF; sgn = 32'h8000_0000; end
        endcase
        r        = cl.is_div ? quo : p[31:0];
        rsp_next = '0;
        if (cl.dz)
            rsp_next.div_by_zero = 1'b1;
        else if (cl.is_wide)
        begin
            rsp_next.result_low    = p[31:0];
            rsp_next.result_high   = p[63:32];
            rsp_next.zero_flag     = (p == '0);
            rsp_next.negative_flag = p[63];
            rsp_next.odd_flag      = p[0];
        end
        else
        begin
            rsp_next.result_low    = r & m;
            rsp_next.zero_flag     = (r == '0);
            rsp_next.negative_flag = |(r & sgn);
            rsp_next.odd_flag      = r[0];
        end
    end

    // hold a waiting result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (adv && vld_reg[STAGES-1])
            ovld_reg <= 1'b1;
        else if (out_ready)
            ovld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[STAGES-1])
            rsp_reg <= rsp_next;
    end

    assign out_valid = ovld_reg;
    assign out_data  = rsp_reg;

endmodule

[rtl/mul_div_execute_unit_top.sv]
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | in_data  (req_t)
// out     | out_valid / out_ready | out_data (rsp_t)
//
// One item per cycle sustained while out_ready stays high; out_valid rises once an
// item has passed the two-entry queue, 32 back stages (the 32-stage quotient pipe
// sets the length) and the output register. A stall on out freezes the back pipe
// once its last stage and the output register are full; the queue keeps taking
// items until full. Reset clears all valid state.
// Depends on mdeu_pkg, mdeu_front, mdeu_back.
module mul_div_execute_unit_top
    import mdeu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);
    logic q_valid, q_ready;
    op_t  q_data;

    mdeu_front #(.DEPTH(DEPTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    mdeu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
